// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file iee_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/iee_pkg.sv =====
// Package for the infix expression evaluator: codes, types, constants.
// Depends on nothing.
package iee_pkg;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int OUT_BITS        = 32;

    typedef enum logic [2:0] {
        OP_LPAR = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
        OP_DIV  = 3'd4, OP_MOD = 3'd5, OP_POW = 3'd6, OP_BAD = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_OVERFLOW = 2'd2, ST_MALFORMED = 2'd3
    } t_status;

    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_MOD  = 8'h25;
    localparam logic [7:0] CH_POW  = 8'h5E;
    localparam logic [7:0] CH_LP   = 8'h28;
    localparam logic [7:0] CH_RP   = 8'h29;

    // What the sequencer is doing for the current character.
    typedef enum logic [1:0] {
        MODE_BIN = 2'd0, MODE_CLOSE = 2'd1, MODE_END = 2'd2, MODE_LPAR = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_FLUSH, S_PEEK, S_DECIDE, S_POPB, S_POPA, S_WAITA, S_EXEC,
        S_ALU, S_PUSHR, S_PUSHOP, S_FINAL, S_RDRES, S_EMIT
    } t_state;

    // Command and status between sequencer and arithmetic unit.
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic divzero;
    } t_alu_sts;

    function automatic logic [1:0] prec(input t_op op);
        logic [1:0] p;
        p = 2'd0;
        case (op)
            OP_ADD, OP_SUB:         p = 2'd1;
            OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
            OP_POW:                 p = 2'd3;
            default:                p = 2'd0;
        endcase
        return p;
    endfunction
endpackage

// ===== rtl/iee_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/iee_alu.sv =====
// Shared iterative arithmetic unit: add/sub in one step, shift-add multiply,
// restoring divide, square-and-multiply power. Depends on iee_pkg.
module iee_alu import iee_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_alu_cmd              i_cmd,
    input  logic [VALUE_BITS-1:0] i_a,
    input  logic [VALUE_BITS-1:0] i_b,
    output t_alu_sts              o_sts,
    output logic [VALUE_BITS-1:0] o_result
);
    localparam int CW = $clog2(VALUE_BITS + 1);
    typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_POWM, A_POWS, A_FIX} t_ast;

    t_ast r_st, n_st;
    t_op  r_op;
    logic [CW-1:0] r_cnt;
    logic [VALUE_BITS-1:0] r_x, r_y, r_acc, r_rem, r_res;
    logic r_neg_q, r_neg_r, r_done, r_dz;
    // multiply sub-step operands (mul and power share the shift-add loop)
    logic [VALUE_BITS-1:0] r_m1, r_m2, r_mp;
    logic [CW-1:0] r_mc;

    wire logic sa = i_a[VALUE_BITS-1];
    wire logic sb = i_b[VALUE_BITS-1];
    wire logic [VALUE_BITS-1:0] ma = sa ? -i_a : i_a;
    wire logic [VALUE_BITS-1:0] mb = sb ? -i_b : i_b;
    wire logic [VALUE_BITS-1:0] ones = '1;
    wire logic [VALUE_BITS-1:0] one = VALUE_BITS'(1);

    logic [VALUE_BITS:0] rem_sh;
    logic [VALUE_BITS:0] rem_sub;
    always_comb begin
        rem_sh  = {r_rem, r_x[VALUE_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_y};
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            A_IDLE: n_st = r_st;
            A_MUL, A_POWM, A_POWS: if (r_mc == CW'(VALUE_BITS)) n_st = A_FIX;
            A_DIV:  if (r_cnt == CW'(VALUE_BITS)) n_st = A_FIX;
            A_FIX:  n_st = A_IDLE;
            default: n_st = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
            r_done <= 1'b0;
        end else begin
            if (r_st == A_IDLE) begin
                if (i_cmd.start) begin
                    r_op <= i_cmd.op;
                    r_cnt <= '0;
                    r_mc <= '0;
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            r_res <= i_a + i_b; r_done <= 1'b1; r_dz <= 1'b0;
                        end
                        OP_SUB: begin
                            r_res <= i_a - i_b; r_done <= 1'b1; r_dz <= 1'b0;
                        end
                        OP_MUL: begin
                            r_m1 <= i_a; r_m2 <= i_b; r_mp <= '0; r_st <= A_MUL;
                            r_done <= 1'b0; r_dz <= 1'b0;
                        end
                        OP_DIV, OP_MOD: begin
                            if (i_b == '0) begin
                                r_dz <= 1'b1; r_res <= '0; r_done <= 1'b1;
                            end else begin
                                r_x <= ma; r_y <= mb; r_rem <= '0;
                                r_neg_q <= sa ^ sb; r_neg_r <= sa;
                                r_st <= A_DIV;
                                r_done <= 1'b0; r_dz <= 1'b0;
                            end
                        end
                        OP_POW: begin
                            if (sb) begin
                                // negative exponent: only 0 as base is an error
                                r_done <= 1'b1;
                                r_dz <= (i_a == '0);
                                if (i_a == one) r_res <= one;
                                else if (i_a == ones) r_res <= i_b[0] ? ones : one;
                                else r_res <= '0;
                            end else begin
                                // r_x: exponent, r_acc: result, r_y: base
                                r_x <= i_b; r_acc <= one; r_y <= i_a;
                                r_m1 <= i_b[0] ? one : i_a; r_m2 <= i_a; r_mp <= '0;
                                r_st <= i_b[0] ? A_POWM : A_POWS;
                                r_done <= 1'b0; r_dz <= 1'b0;
                            end
                        end
                        default: begin
                            r_res <= '0; r_done <= 1'b1; r_dz <= 1'b0;
                        end
                    endcase
                end else begin
                    r_done <= 1'b0;
                end
            end else if (r_st == A_DIV) begin
                if (r_cnt != CW'(VALUE_BITS)) begin
                    if (!rem_sub[VALUE_BITS]) begin
                        r_rem <= rem_sub[VALUE_BITS-1:0];
                        r_x <= {r_x[VALUE_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[VALUE_BITS-1:0];
                        r_x <= {r_x[VALUE_BITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    r_done <= 1'b0;
                end else begin
                    r_st <= A_IDLE;
                    r_done <= 1'b1;
                    if (r_op == OP_DIV) r_res <= r_neg_q ? -r_x : r_x;
                    else r_res <= r_neg_r ? -r_rem : r_rem;
                end
            end else if (r_st == A_MUL) begin
                if (r_mc != CW'(VALUE_BITS)) begin
                    if (r_m2[0]) r_mp <= r_mp + r_m1;
                    r_m1 <= r_m1 << 1;
                    r_m2 <= r_m2 >> 1;
                    r_mc <= r_mc + CW'(1);
                    r_done <= 1'b0;
                end else begin
                    r_res <= r_mp; r_done <= 1'b1; r_st <= A_IDLE;
                end
            end else if (r_st == A_POWM || r_st == A_POWS) begin
                // one shift-add multiply: POWM gives acc*base, POWS base*base
                if (r_mc != CW'(VALUE_BITS)) begin
                    if (r_m2[0]) r_mp <= r_mp + r_m1;
                    r_m1 <= r_m1 << 1;
                    r_m2 <= r_m2 >> 1;
                    r_mc <= r_mc + CW'(1);
                    r_done <= 1'b0;
                end else begin
                    r_mc <= '0;
                    r_mp <= '0;
                    if (r_st == A_POWM) begin
                        r_acc <= r_mp;
                        r_m1 <= r_y; r_m2 <= r_y;
                        r_st <= A_POWS;
                        r_done <= 1'b0;
                    end else begin
                        r_y <= r_mp;
                        r_x <= r_x >> 1;
                        r_cnt <= r_cnt + CW'(1);
                        if (r_cnt == CW'(VALUE_BITS - 1) || (r_x >> 1) == '0) begin
                            r_res <= r_acc; r_done <= 1'b1; r_st <= A_IDLE;
                        end else if (r_x[1]) begin
                            r_m1 <= r_acc; r_m2 <= r_mp; r_st <= A_POWM;
                            r_done <= 1'b0;
                        end else begin
                            r_m1 <= r_mp; r_m2 <= r_mp; r_st <= A_POWS;
                            r_done <= 1'b0;
                        end
                    end
                end
            end else begin
                r_st <= n_st;
                r_done <= 1'b0;
            end
        end
    end

    assign o_sts.busy    = (r_st != A_IDLE);
    assign o_sts.done    = r_done;
    assign o_sts.divzero = r_dz;
    assign o_result      = r_res;
endmodule

// ===== rtl/infix_expression_evaluator_top.sv =====
// Infix expression evaluator: one ASCII character per input transfer, ready low while busy.
// A digit is taken in the idle state; any other character flushes the number, an ignored one
// stops there, and an operator, close paren or newline may reduce the stacks through the ALU,
// which does ^ by square-and-multiply. A newline's result goes to one output register, which lets
// the next line start while a result waits. Synchronous active-low reset clears counts,
// accumulator, status and output valid. Depends on iee_pkg, iee_ram, iee_alu.
module infix_expression_evaluator_top import iee_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char_code,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [31:0] o_value,
    output logic [1:0]        o_status
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state r_state, n_state;
    t_mode  r_mode;
    t_op    r_op_in;          // operator being pushed (binary or left-paren mode)
    t_op    r_top;            // popped operator under reduction
    logic [CW-1:0] r_vcnt, r_ocnt;
    logic [VALUE_BITS-1:0] r_acc, r_b, r_a;
    logic   r_innum;
    t_status r_lst;
    logic   r_ovalid;
    logic [31:0] r_oval;
    logic [1:0]  r_osts;

    // value and operator stack RAMs
    logic v_we; logic [AW-1:0] v_wa, v_ra; logic [VALUE_BITS-1:0] v_wd, v_rd;
    logic o_we; logic [AW-1:0] o_wa, o_ra; logic [2:0] o_wd, o_rd;

    iee_ram #(.WIDTH(VALUE_BITS), .DEPTH(STACK_DEPTH)) u_vstk (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));
    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_ostk (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_wa), .i_wdata(o_wd),
        .i_raddr(o_ra), .o_rdata(o_rd));

    t_alu_cmd alu_cmd;
    t_alu_sts alu_sts;
    logic [VALUE_BITS-1:0] alu_res;
    iee_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(alu_cmd), .i_a(r_a), .i_b(r_b),
        .o_sts(alu_sts), .o_result(alu_res));

    wire logic in_xfer  = i_valid && o_ready;
    wire logic out_xfer = r_ovalid && i_ready;
    wire logic is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    wire logic vfull = (r_vcnt == CW'(STACK_DEPTH));
    wire logic ofull = (r_ocnt == CW'(STACK_DEPTH));
    wire t_op  peek  = t_op'(o_rd);
    wire logic ok    = (r_lst == ST_OK);
    // result register free (or freed this cycle) while in S_EMIT
    wire logic emit_go = (r_state == S_EMIT) && (!r_ovalid || out_xfer);

    // character decode: operator code and sequencer mode
    t_op   in_op;
    t_mode in_mode;
    always_comb begin
        in_op   = OP_BAD;
        in_mode = MODE_BIN;
        unique case (i_char_code)
            CH_ADD: in_op = OP_ADD;
            CH_SUB: in_op = OP_SUB;
            CH_MUL: in_op = OP_MUL;
            CH_DIV: in_op = OP_DIV;
            CH_MOD: in_op = OP_MOD;
            CH_POW: in_op = OP_POW;
            CH_LP: begin
                in_op   = OP_LPAR;
                in_mode = MODE_LPAR;
            end
            CH_RP:  in_mode = MODE_CLOSE;
            CH_NL:  in_mode = MODE_END;
            default: ;
        endcase
    end

    // decide whether the operator on top gets reduced
    logic do_reduce;
    always_comb begin
        do_reduce = 1'b0;
        if (peek != OP_LPAR) begin
            if (r_mode == MODE_BIN)
                do_reduce = (prec(peek) > prec(r_op_in)) ||
                            ((prec(peek) == prec(r_op_in)) && (r_op_in != OP_POW));
            else
                do_reduce = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_xfer && !is_digit && (i_char_code == CH_NL || ok))
                          n_state = S_FLUSH;
            // ignored characters stop after the number flush
            S_FLUSH:  n_state = (r_mode == MODE_BIN && r_op_in == OP_BAD) ? S_IDLE : S_PEEK;
            S_PEEK: begin
                if (!ok) n_state = (r_mode == MODE_END) ? S_FINAL : S_IDLE;
                else if (r_ocnt == '0) begin
                    unique case (r_mode)
                        MODE_BIN, MODE_LPAR: n_state = S_PUSHOP;
                        MODE_CLOSE: n_state = S_IDLE;
                        default:    n_state = S_FINAL;
                    endcase
                end else if (r_mode == MODE_LPAR) n_state = S_PUSHOP;
                else n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_mode == MODE_END && peek == OP_LPAR) n_state = S_FINAL;
                else if (do_reduce) n_state = S_POPB;
                else if (r_mode == MODE_BIN) n_state = S_PUSHOP;
                else n_state = S_IDLE;
            end
            S_POPB:   n_state = (r_vcnt < CW'(2)) ? S_PEEK : S_POPA;
            S_POPA:   n_state = S_WAITA;
            S_WAITA:  n_state = S_EXEC;
            S_EXEC:   n_state = S_ALU;
            S_ALU:    if (alu_sts.done) n_state = S_PUSHR;
            S_PUSHR:  n_state = S_PEEK;
            S_PUSHOP: n_state = S_IDLE;
            S_FINAL:  n_state = S_RDRES;
            S_RDRES:  n_state = S_EMIT;
            S_EMIT:   if (!r_ovalid || out_xfer) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // stack port and ALU controls
    always_comb begin
        v_we = 1'b0; v_wa = r_vcnt[AW-1:0]; v_wd = r_acc;
        v_ra = '0;
        o_we = 1'b0; o_wa = r_ocnt[AW-1:0]; o_wd = r_op_in;
        o_ra = AW'(r_ocnt - CW'(1));
        alu_cmd.start = 1'b0; alu_cmd.op = r_top;
        unique case (r_state)
            S_FLUSH:  v_we = r_innum && ok && !vfull;
            S_POPB:   v_ra = AW'(r_vcnt - CW'(1));
            S_POPA:   v_ra = AW'(r_vcnt - CW'(1));
            S_EXEC:   alu_cmd.start = 1'b1;
            S_PUSHR: begin
                v_we = !alu_sts.divzero && !vfull;
                v_wd = alu_res;
            end
            S_PUSHOP: o_we = !ofull;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt <= '0; r_ocnt <= '0; r_acc <= '0; r_innum <= 1'b0;
            r_lst <= ST_OK; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_go) r_ovalid <= 1'b1;
            else if (out_xfer) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_xfer && (i_char_code == CH_NL || ok)) begin
                    r_op_in <= in_op;
                    r_mode <= in_mode;
                    if (is_digit) begin
                        r_acc <= VALUE_BITS'(r_acc * VALUE_BITS'(10))
                               + VALUE_BITS'(i_char_code - CH_ZERO);
                        r_innum <= 1'b1;
                    end
                end
                S_FLUSH: begin
                    if (r_innum && ok) begin
                        if (vfull) r_lst <= ST_OVERFLOW;
                        else r_vcnt <= r_vcnt + CW'(1);
                    end
                    r_innum <= 1'b0;
                    r_acc <= '0;
                end
                S_PEEK: if (ok && r_ocnt == '0 && r_mode == MODE_CLOSE)
                    r_lst <= ST_MALFORMED;
                S_DECIDE: begin
                    if (r_mode == MODE_END && peek == OP_LPAR) r_lst <= ST_MALFORMED;
                    else if (do_reduce) begin
                        r_top <= peek;
                        r_ocnt <= r_ocnt - CW'(1);
                    end else if (r_mode == MODE_CLOSE) r_ocnt <= r_ocnt - CW'(1);
                end
                S_POPB: if (r_vcnt < CW'(2)) r_lst <= ST_MALFORMED;
                    else r_vcnt <= r_vcnt - CW'(1);
                // right operand read in S_POPB arrives here, left one in S_WAITA
                S_POPA: begin
                    r_vcnt <= r_vcnt - CW'(1);
                    r_b <= v_rd;
                end
                S_WAITA: r_a <= v_rd;
                S_PUSHR: begin
                    if (alu_sts.divzero) r_lst <= ST_DIVZERO;
                    else if (vfull) r_lst <= ST_OVERFLOW;
                    else r_vcnt <= r_vcnt + CW'(1);
                end
                S_PUSHOP: if (ofull) r_lst <= ST_OVERFLOW;
                    else r_ocnt <= r_ocnt + CW'(1);
                S_FINAL: if (ok && r_vcnt != CW'(1)) r_lst <= ST_MALFORMED;
                S_EMIT: if (emit_go) begin
                    r_osts <= r_lst;
                    r_oval <= (r_lst == ST_OK) ? 32'(v_rd) : 32'd0;
                    r_vcnt <= '0; r_ocnt <= '0; r_acc <= '0;
                    r_innum <= 1'b0; r_lst <= ST_OK;
                end
                default: ;
            endcase
        end
    end

    // Value read at S_RDRES sees address 0 (default v_ra), held into S_EMIT.
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_value  = signed'(r_oval);
    assign o_status = r_osts;
endmodule

// ===== rtl/iee_checker.sv =====
// Port-level checker for the infix expression evaluator, bound to the top.
// Depends on iee_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iee_checker import iee_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_char_code,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value,
    input logic [1:0]  o_status
);
    `CHK_IMPLY(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_value == 32'd0, "nonzero value with error")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_value) && $stable(o_status), "result changed while stalled")
    `CHK_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready && i_char_code == CH_NL, !o_ready, "ready right after newline")
    `CHK_NEXT(a_nl_only, i_clk, i_rst_n, !o_valid && o_ready, !o_valid, "result without newline")
endmodule

bind infix_expression_evaluator_top iee_checker u_chk (.*);

// ===== tb/tb_infix_expression_evaluator_top.sv =====
// Testbench for the infix expression evaluator: character stream in, one result per line out.
// Expected results come from an in-bench two-stack evaluator; depends on iee_pkg and the RTL.
`timescale 1ns / 100ps
module tb_infix_expression_evaluator_top;
    import iee_pkg::*;

    localparam int DEPTH     = STACK_DEPTH_DEF;
    localparam int IDLE_LIMIT = 200000;   // watchdog limit on idle cycles; power lines are the slowest

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [7:0]        i_char_code;
    logic              o_valid;
    logic              i_ready;
    logic signed [31:0] o_value;
    logic [1:0]        o_status;

    infix_expression_evaluator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_char_code(i_char_code),
        .o_valid(o_valid), .i_ready(i_ready), .o_value(o_value), .o_status(o_status)
    );

    // Clock: 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Expected line results, oldest first.
    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_line_result;
    t_line_result line_results[$];

    int errors = 0;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;      // long receiver hold-off for the backpressure test
    int idle_cycles = 0;

    // Evaluator shadow state.
    logic [31:0] vals[DEPTH];
    t_op         ops[DEPTH];
    int          nvals, nops;
    logic [31:0] acc;
    bit          in_num;
    t_status     lstat;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic void set_fail(input t_status code);
        if (lstat == ST_OK) lstat = code;
    endfunction

    function automatic void clear_line();
        nvals = 0; nops = 0; acc = '0; in_num = 0; lstat = ST_OK;
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (nvals >= DEPTH) begin
            set_fail(ST_OVERFLOW);
            return;
        end
        vals[nvals] = v;
        nvals++;
    endfunction

    function automatic void push_oper(input t_op op);
        if (nops >= DEPTH) begin
            set_fail(ST_OVERFLOW);
            return;
        end
        ops[nops] = op;
        nops++;
    endfunction

    function automatic void end_number();
        if (in_num) push_val(acc);
        in_num = 0;
        acc = '0;
    endfunction

    function automatic int rank(input t_op op);
        case (op)
            OP_ADD, OP_SUB:         return 1;
            OP_MUL, OP_DIV, OP_MOD: return 2;
            OP_POW:                 return 3;
            default:                return 0;
        endcase
    endfunction

    function automatic logic [31:0] raise(input logic [31:0] base, input logic [31:0] ex);
        logic [31:0] r;
        logic [31:0] b;
        r = 32'd1;
        b = base;
        if (ex[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            if (base == 32'd0) set_fail(ST_DIVZERO);
            return 32'd0;
        end
        for (int i = 0; i < 32; i++) begin
            if (ex[i]) r = r * b;
            b = b * b;
        end
        return r;
    endfunction

    // Pop one operator and two operands, push the result.
    function automatic void reduce_top();
        t_op         op;
        logic [31:0] a, b, r, ma, mb;
        if (nops == 0) return;
        nops--;
        op = ops[nops];
        if (nvals < 2) begin
            set_fail(ST_MALFORMED);
            return;
        end
        b = vals[nvals-1];
        a = vals[nvals-2];
        nvals -= 2;
        r = '0;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV, OP_MOD: begin
                if (b == 0) begin
                    set_fail(ST_DIVZERO);
                    return;
                end
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                if (op == OP_DIV) begin
                    r = ma / mb;
                    if (a[31] != b[31]) r = -r;
                end else begin
                    r = ma % mb;
                    if (a[31]) r = -r;
                end
            end
            OP_POW: r = raise(a, b);
            default: begin
                set_fail(ST_MALFORMED);
                return;
            end
        endcase
        push_val(r);
    endfunction

    function automatic void apply_operator(input t_op op);
        int p;
        p = rank(op);
        end_number();
        while (lstat == ST_OK && nops > 0) begin
            if (ops[nops-1] == OP_LPAR) break;
            if (rank(ops[nops-1]) > p || (rank(ops[nops-1]) == p && op != OP_POW))
                reduce_top();
            else
                break;
        end
        if (lstat == ST_OK) push_oper(op);
    endfunction

    // Advance the shadow evaluator by one character; queue a result on newline.
    function automatic void evaluate_char(input logic [7:0] c);
        t_line_result res;
        if (c == CH_NL) begin
            end_number();
            while (lstat == ST_OK && nops > 0) begin
                if (ops[nops-1] == OP_LPAR) begin
                    set_fail(ST_MALFORMED);
                    break;
                end
                reduce_top();
            end
            if (lstat == ST_OK && nvals != 1) set_fail(ST_MALFORMED);
            res.value  = (lstat == ST_OK) ? vals[0] : 32'd0;
            res.status = lstat;
            line_results.push_back(res);
            clear_line();
            return;
        end
        if (lstat != ST_OK) return;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            acc = acc * 10 + (c - CH_ZERO);
            in_num = 1;
            return;
        end
        case (c)
            CH_ADD: apply_operator(OP_ADD);
            CH_SUB: apply_operator(OP_SUB);
            CH_MUL: apply_operator(OP_MUL);
            CH_DIV: apply_operator(OP_DIV);
            CH_MOD: apply_operator(OP_MOD);
            CH_POW: apply_operator(OP_POW);
            CH_LP: begin
                end_number();
                if (lstat == ST_OK) push_oper(OP_LPAR);
            end
            CH_RP: begin
                end_number();
                while (lstat == ST_OK) begin
                    if (nops == 0) begin
                        set_fail(ST_MALFORMED);
                        break;
                    end
                    if (ops[nops-1] == OP_LPAR) begin
                        nops--;
                        break;
                    end
                    reduce_top();
                end
            end
            default: end_number();
        endcase
    endfunction

    // Send one character: optional idle gap, then hold valid until the transfer.
    // Valid stays high after the transfer; the next call's idle gap or stop_sending drops it.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (!o_ready);
        evaluate_char(c);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CH_NL);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (line_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver ready: random stalls, or held off entirely.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (line_results.size() == 0) begin
                report_mismatch("unexpected result", o_value, 32'd0);
            end else begin
                want = line_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", {30'd0, o_status}, {30'd0, want.status});
                if (o_value !== want.value)
                    report_mismatch("value", o_value, want.value);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Random digit string, mostly short, sometimes long enough to wrap.
    function automatic string rand_number();
        string s;
        int n;
        s = "";
        n = ($urandom_range(15) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_oper();
        case ($urandom_range(9))
            0, 1:    return "+";
            2, 3:    return "-";
            4, 5:    return "*";
            6:       return "/";
            7:       return "%";
            default: return ($urandom_range(3) == 0) ? "^" : "*";
        endcase
    endfunction

    // Well-formed expression with random nesting; depth kept moderate.
    function automatic string rand_expr(input int lvl);
        string s;
        int terms;
        s = "";
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) s = {s, rand_oper()};
            if (lvl < 3 && $urandom_range(4) == 0) s = {s, "(", rand_expr(lvl + 1), ")"};
            else s = {s, rand_number()};
        end
        return s;
    endfunction

    task automatic test_directed();
        send_line("0");
        send_line("4294967295");             // max accumulator
        send_line("99999999999");            // accumulator wraps
        send_line("7+3-2*4/3%5");
        send_line("2^3^2");                  // right-associative power
        send_line("8-3-2");                  // left-associative
        send_line("(1+2)*(3+4)");
        send_line("5/0");                    // divide by zero
        send_line("5%0");
        send_line("0-7/2");                  // truncation toward zero
        send_line("(0-7)%2");
        send_line("(0-2147483647-1)/(0-1)"); // most negative over -1
        send_line("2^(0-1)");                // negative exponent cases
        send_line("1^(0-3)");
        send_line("(0-1)^(0-3)");
        send_line("0^(0-1)");
        send_line("0^0");
        send_line("");                       // empty line
        send_line("1+");                     // missing operand
        send_line("(1+2");                   // unclosed paren
        send_line("1+2)");                   // unmatched close
        send_line("((((((((((((((((1))))))))))))))))"); // nesting to the full operator stack depth
        send_line("1+(2+(3+(4+(5+(6+(7+(8+(9+(1+(2+(3+(4+(5+(6+(7+8)))))))))))))))");
        send_line("1/0+2 ab\xff");           // chars after error ignored
        send_line("12 34");                  // ignored char splits numbers
        send_char(8'hFF); send_char(8'h00); send_line("3");
    endtask

    // Mostly well-formed lines, some broken or noisy.
    task automatic test_random(input int n_chars);
        int sent;
        string s;
        sent = 0;
        while (sent < n_chars) begin
            case ($urandom_range(9))
                0: begin
                    s = "";
                    repeat ($urandom_range(1, 12)) s = {s, string'(8'($urandom_range(255)))};
                end
                1: s = {rand_expr(0), rand_oper()};
                2: s = {"(", rand_expr(0)};
                default: s = rand_expr(0);
            endcase
            for (int i = 0; i < s.len(); i++) if (s[i] == CH_NL) s[i] = " ";
            send_line(s);
            sent += s.len() + 1;
        end
    endtask

    // Receiver holds off while lines keep coming, so the block stalls its input.
    task automatic test_backpressure();
        recv_hold = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                recv_hold = 0;
            end
            begin
                for (int i = 0; i < 6; i++) send_line(rand_expr(0));
                stop_sending();
            end
        join
        wait_drained();   // sender pauses until everything has come back
    endtask

    initial begin
        recv_hold     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_valid       = 1'b0;
        i_char_code   = 8'd0;
        i_rst_n       = 1'b0;
        clear_line();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 13; recv_idle_pct = 88;
        test_directed();
        test_random(500);
        test_backpressure();
        send_idle_pct = 88; recv_idle_pct = 13;
        test_random(500);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(500);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/iee_pkg.sv
rtl/iee_ram.sv
rtl/iee_alu.sv
rtl/infix_expression_evaluator_top.sv
rtl/iee_checker.sv
tb/tb_infix_expression_evaluator_top.sv
